// ----- rtl/core/led_blk_pkg.sv -----
`default_nettype none
package led_blk_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_SELECT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALGO_INDEX  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_WORD  = 8'd3;

  // Mode select values.
  localparam logic MODE_PWM    = 1'b0;
  localparam logic MODE_SWITCH = 1'b1;

  // Switch mode algorithms.
  localparam logic [2:0] SW_OFF   = 3'd0;
  localparam logic [2:0] SW_FLASH = 3'd1;
  localparam logic [2:0] SW_PULSE = 3'd2;
  localparam logic [2:0] SW_ON    = 3'd3;

  // PWM mode algorithms.
  localparam logic [2:0] PWM_OFF   = 3'd0;
  localparam logic [2:0] PWM_LEVEL = 3'd1;

  localparam logic [7:0] LEVEL_OFF  = 8'h00;
  localparam logic [7:0] LEVEL_FULL = 8'hff;

  // Configuration register set.
  typedef struct packed {
    logic       mode_select;
    logic [2:0] algo_index;
    logic [7:0] period;
    logic [7:0] flash_word;
  } cfg_t;

  // Channel state carried from one step to the next.
  typedef struct packed {
    logic [7:0] tick_count;
    logic [1:0] flashes_left;
    logic       output_on;
    logic       off_between_flashes;
    logic       start_mark;
    logic       reached_mark;
    logic [7:0] last_level;
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/led_blk_cfg.sv -----
`default_nettype none
module led_blk_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [led_blk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]                         cfg_data,
  output led_blk_pkg::cfg_t                       cfg
);

  led_blk_pkg::cfg_t cfg_r;
  led_blk_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  // Decode a write transfer; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        led_blk_pkg::REG_MODE_SELECT: cfg_nxt.mode_select = cfg_data[0];
        led_blk_pkg::REG_ALGO_INDEX:  cfg_nxt.algo_index  = cfg_data[2:0];
        led_blk_pkg::REG_PERIOD:      cfg_nxt.period      = cfg_data;
        led_blk_pkg::REG_FLASH_WORD:  cfg_nxt.flash_word  = cfg_data;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_select <= led_blk_pkg::MODE_SWITCH;
      cfg_r.algo_index  <= led_blk_pkg::SW_OFF;
      cfg_r.period      <= 8'd1;
      cfg_r.flash_word  <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/led_blk_step.sv -----
`default_nettype none
module led_blk_step (
  input  wire led_blk_pkg::cfg_t   cfg,
  input  wire led_blk_pkg::state_t state,
  input  wire logic                tick,
  input  wire logic                restart,
  output led_blk_pkg::state_t      state_nxt
);

  logic [7:0] count_dec;
  logic [7:0] phase_len;

  assign count_dec = state.tick_count - 8'd1;
  assign phase_len = {2'b00, cfg.flash_word[7:2]} + 8'd1;

  always_comb begin
    state_nxt = state;
    state_nxt.start_mark   = state.start_mark | restart;
    state_nxt.reached_mark = 1'b0;

    // Tick counter with reload from the period register.
    if (tick) begin
      if (count_dec == 8'd0) begin
        state_nxt.tick_count   = cfg.period;
        state_nxt.reached_mark = 1'b1;
      end else begin
        state_nxt.tick_count = count_dec;
      end
    end

    // Algorithm evaluation.
    if (cfg.mode_select == led_blk_pkg::MODE_SWITCH) begin
      case (cfg.algo_index)
        led_blk_pkg::SW_OFF: state_nxt.last_level = led_blk_pkg::LEVEL_OFF;
        led_blk_pkg::SW_FLASH: begin
          if (state_nxt.reached_mark) begin
            if (state.output_on) begin
              state_nxt.output_on = 1'b0;
              if (state.flashes_left != 2'd0) begin
                state_nxt.flashes_left        = state.flashes_left - 2'd1;
                state_nxt.off_between_flashes = 1'b1;
                state_nxt.tick_count          = phase_len;
              end else begin
                state_nxt.off_between_flashes = 1'b0;
              end
              state_nxt.last_level = led_blk_pkg::LEVEL_OFF;
            end else begin
              if (!state.off_between_flashes) begin
                state_nxt.flashes_left = cfg.flash_word[1:0];
              end
              state_nxt.tick_count = phase_len;
              state_nxt.output_on  = 1'b1;
              state_nxt.last_level = led_blk_pkg::LEVEL_FULL;
            end
          end
        end
        led_blk_pkg::SW_PULSE: begin
          if (state_nxt.start_mark) begin
            state_nxt.last_level = led_blk_pkg::LEVEL_FULL;
          end else if (state_nxt.reached_mark) begin
            state_nxt.last_level = led_blk_pkg::LEVEL_OFF;
          end
        end
        led_blk_pkg::SW_ON: state_nxt.last_level = led_blk_pkg::LEVEL_FULL;
        default: state_nxt.last_level = state.last_level;
      endcase
    end else begin
      case (cfg.algo_index)
        led_blk_pkg::PWM_OFF:   state_nxt.last_level = led_blk_pkg::LEVEL_OFF;
        led_blk_pkg::PWM_LEVEL: state_nxt.last_level = cfg.flash_word;
        default:                state_nxt.last_level = state.last_level;
      endcase
    end

    // The start mark lasts for one step only.
    state_nxt.start_mark = 1'b0;
  end

endmodule
`default_nettype wire

// ----- rtl/core/led_blk_out.sv -----
`default_nettype none
module led_blk_out (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire logic [7:0] level,
  output logic            free,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata
);

  logic       valid_r;
  logic [7:0] data_r;

  // The register can take a new result when empty or when draining now.
  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data_r <= level;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/led_blink_channel.sv -----
`default_nettype none
// One lighting channel. Each transfer on the input channel is one evaluation
// step: in_tdata bit 0 marks a time tick, bit 1 requests a restart. Every
// step yields exactly one result transfer carrying the channel brightness.
//
// Registers are written through the cfg channel (index 0 mode select,
// 1 algorithm, 2 period, 3 flash word); the user must write them only
// while the channel is idle, as the block makes no such check. cfg_ready
// is always high and unknown indexes are ignored.
//
// An input transfer passes through the input register, then the state
// update and the result register, before out_tvalid rises. One item is
// accepted per cycle when the receiver keeps out_tready high.
//
// Synchronous reset restores the register defaults and the channel state
// and empties both stages. When the receiver stalls, the result register
// holds its value and the input register fills, after which in_tready
// drops until the result is taken.
module led_blink_channel (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: [0] tick, [1] restart, [7:2] zero.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,
  // out_tdata: [7:0] level.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [7:0]                             out_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [led_blk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                        cfg_data
);

  led_blk_pkg::cfg_t   cfg;
  led_blk_pkg::state_t state_r;
  led_blk_pkg::state_t state_nxt;

  logic in_valid_r;
  logic tick_r;
  logic restart_r;
  logic out_free;
  logic step_en;

  // Configuration registers.
  led_blk_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // A step runs when an item waits and the result register has room.
  assign step_en   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      tick_r    <= in_tdata[0];
      restart_r <= in_tdata[1];
    end
  end

  // Step logic.
  led_blk_step u_step (
    .cfg       (cfg),
    .state     (state_r),
    .tick      (tick_r),
    .restart   (restart_r),
    .state_nxt (state_nxt)
  );

  // Channel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.tick_count          <= 8'd1;
      state_r.flashes_left        <= 2'd0;
      state_r.output_on           <= 1'b0;
      state_r.off_between_flashes <= 1'b0;
      state_r.start_mark          <= 1'b1;
      state_r.reached_mark        <= 1'b0;
      state_r.last_level          <= led_blk_pkg::LEVEL_OFF;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  led_blk_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_valid_r),
    .level      (state_nxt.last_level),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // A step always leaves a result waiting.
  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_tvalid)
    else $error("step finished without a pending result");

  // State moves only on a step.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(state_r))
    else $error("channel state changed without a step");

  // The start mark never survives a step.
  a_start_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> !state_r.start_mark)
    else $error("start mark still set after a step");

  // A waiting item is not lost while the result side stalls.
  a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_free |=> in_valid_r && $stable(tick_r) && $stable(restart_r))
    else $error("stalled input item was dropped");

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
module tb;

  // Codes that the block must ignore or treat as out of range.
  localparam logic [2:0] SW_UNUSED          = 3'd7;
  localparam logic [2:0] PWM_UNUSED         = 3'd2;
  localparam logic [7:0] REG_UNUSED_FIRST   = 8'd4;
  localparam logic [7:0] REG_UNUSED_LAST    = 8'hff;

  localparam int TARGET_STEPS   = 1600;
  localparam int RESTART_PCT    = 8;
  localparam int IDLE_PCT       = 30;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int LONG_RUN_PHASE = 5;
  localparam int STALL_PHASE    = 10;
  localparam int SETTLE_CYCLES  = 8;

  // One row of the directed table: a register write or one channel step.
  typedef struct packed {
    logic       is_write;
    logic [7:0] reg_idx;
    logic [7:0] reg_data;
    logic       tick;
    logic       restart;
    logic       typed;
    logic [7:0] level;
  } step_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_index;
  logic [7:0] cfg_data;

  // Level typed into the table for the step now on offer, if any.
  logic       row_has_level;
  logic [7:0] row_level;

  // Predictor copy of the registers and of the channel state.
  led_blk_pkg::cfg_t   regs;
  led_blk_pkg::state_t chan;
  logic [7:0]          predicted;

  logic [7:0] expected_levels [$];
  step_row_t  directed_rows [$];
  int         mismatch_count;
  int         steps_sent;
  int         steps_checked;
  int         writes_done;
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         rx_hold_request;
  int         rx_hold_left;

  led_blink_channel uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic step_row_t reg_row(input logic [7:0] idx, input logic [7:0] data);
    step_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic step_row_t step_row(input logic tk, input logic rs);
    step_row_t r;
    r = '0;
    r.tick    = tk;
    r.restart = rs;
    return r;
  endfunction

  function automatic step_row_t known_row(input logic tk, input logic rs,
                                          input logic [7:0] lvl);
    step_row_t r;
    r = step_row(tk, rs);
    r.typed = 1'b1;
    r.level = lvl;
    return r;
  endfunction

  // Advance the channel by one step and return the brightness it reports.
  function automatic logic [7:0] step_channel(input logic tk, input logic rs);
    logic [7:0] phase_ticks;
    phase_ticks = regs.flash_word[7:2] + 8'd1;
    if (rs) begin
      chan.start_mark = 1'b1;
    end
    chan.reached_mark = 1'b0;
    if (tk) begin
      chan.tick_count = chan.tick_count - 8'd1;
      if (chan.tick_count == 8'd0) begin
        chan.tick_count   = regs.period;
        chan.reached_mark = 1'b1;
      end
    end
    if (regs.mode_select == led_blk_pkg::MODE_SWITCH) begin
      case (regs.algo_index)
        led_blk_pkg::SW_OFF: begin
          chan.last_level = led_blk_pkg::LEVEL_OFF;
        end
        led_blk_pkg::SW_FLASH: begin
          if (chan.reached_mark && chan.output_on) begin
            // End of an on phase: either a gap inside the burst or the long off.
            chan.output_on = 1'b0;
            if (chan.flashes_left != 2'd0) begin
              chan.flashes_left        = chan.flashes_left - 2'd1;
              chan.off_between_flashes = 1'b1;
              chan.tick_count          = phase_ticks;
            end else begin
              chan.off_between_flashes = 1'b0;
            end
            chan.last_level = led_blk_pkg::LEVEL_OFF;
          end else if (chan.reached_mark) begin
            // A new burst loads its flash count; a gap inside the burst does not.
            if (!chan.off_between_flashes) begin
              chan.flashes_left = regs.flash_word[1:0];
            end
            chan.tick_count = phase_ticks;
            chan.output_on  = 1'b1;
            chan.last_level = led_blk_pkg::LEVEL_FULL;
          end
        end
        led_blk_pkg::SW_PULSE: begin
          if (chan.start_mark) begin
            chan.last_level = led_blk_pkg::LEVEL_FULL;
          end else if (chan.reached_mark) begin
            chan.last_level = led_blk_pkg::LEVEL_OFF;
          end
        end
        led_blk_pkg::SW_ON: begin
          chan.last_level = led_blk_pkg::LEVEL_FULL;
        end
        default: begin
        end
      endcase
    end else begin
      case (regs.algo_index)
        led_blk_pkg::PWM_OFF: begin
          chan.last_level = led_blk_pkg::LEVEL_OFF;
        end
        led_blk_pkg::PWM_LEVEL: begin
          chan.last_level = regs.flash_word;
        end
        default: begin
        end
      endcase
    end
    chan.start_mark = 1'b0;
    return chan.last_level;
  endfunction

  // Watch all three channels at each edge: register writes and steps feed the
  // predictor, result transfers are checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          led_blk_pkg::REG_MODE_SELECT: regs.mode_select = cfg_data[0];
          led_blk_pkg::REG_ALGO_INDEX:  regs.algo_index  = cfg_data[2:0];
          led_blk_pkg::REG_PERIOD:      regs.period      = cfg_data;
          led_blk_pkg::REG_FLASH_WORD:  regs.flash_word  = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready) begin
        predicted = step_channel(in_tdata[0], in_tdata[1]);
        expected_levels.push_back(row_has_level ? row_level : predicted);
      end
      if (out_tvalid && out_tready) begin
        steps_checked++;
        if (expected_levels.size() == 0) begin
          $error("level: no step outstanding, actual %0d", out_tdata);
          mismatch_count++;
        end else begin
          predicted = expected_levels.pop_front();
          if (out_tdata !== predicted) begin
            $error("level: expected %0d, actual %0d", predicted, out_tdata);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_request != 0) begin
        rx_hold_left    = RX_HOLD_CYCLES;
        rx_hold_request = 0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offer one step and wait for its transfer; valid stays high afterwards.
  task automatic send_item(input logic tk, input logic rs, input logic typed,
                           input logic [7:0] lvl);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_tvalid     <= 1'b1;
    in_tdata      <= {6'b0, rs, tk};
    row_has_level <= typed;
    row_level     <= lvl;
    do @(posedge clk); while (!in_tready);
    steps_sent++;
  endtask

  // Stop offering steps and wait until every result has come back.
  task automatic finish_items();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_levels.size() != 0);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    writes_done++;
  endtask

  initial begin
    int         phase;
    int         n_items;
    int         tick_pct;
    logic [7:0] v;

    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = 8'd0;
    cfg_valid       = 1'b0;
    cfg_index       = 8'd0;
    cfg_data        = 8'd0;
    row_has_level   = 1'b0;
    row_level       = 8'd0;
    mismatch_count  = 0;
    steps_sent      = 0;
    steps_checked   = 0;
    writes_done     = 0;
    tx_idle_pct     = IDLE_PCT;
    rx_idle_pct     = IDLE_PCT;
    rx_hold_request = 0;
    rx_hold_left    = 0;
    regs = '{mode_select: led_blk_pkg::MODE_SWITCH, algo_index: led_blk_pkg::SW_OFF,
             period: 8'd1, flash_word: 8'd0};
    chan = '{tick_count: 8'd1, flashes_left: 2'd0, output_on: 1'b0,
             off_between_flashes: 1'b0, start_mark: 1'b1, reached_mark: 1'b0,
             last_level: led_blk_pkg::LEVEL_OFF};

    // Directed steps: reset values, both modes, out-of-range algorithms,
    // ignored register indexes, a flash burst, a pulse and period extremes.
    directed_rows = '{
      known_row(1'b0, 1'b0, led_blk_pkg::LEVEL_OFF),
      known_row(1'b1, 1'b0, led_blk_pkg::LEVEL_OFF),
      reg_row(led_blk_pkg::REG_ALGO_INDEX, 8'(led_blk_pkg::SW_ON)),
      known_row(1'b0, 1'b1, led_blk_pkg::LEVEL_FULL),
      reg_row(led_blk_pkg::REG_MODE_SELECT, 8'(led_blk_pkg::MODE_PWM)),
      reg_row(led_blk_pkg::REG_FLASH_WORD, 8'ha5),
      reg_row(led_blk_pkg::REG_ALGO_INDEX, 8'(led_blk_pkg::PWM_LEVEL)),
      known_row(1'b1, 1'b0, 8'ha5),
      reg_row(led_blk_pkg::REG_FLASH_WORD, 8'hff),
      known_row(1'b0, 1'b0, 8'hff),
      reg_row(led_blk_pkg::REG_ALGO_INDEX, 8'(SW_UNUSED)),
      reg_row(led_blk_pkg::REG_FLASH_WORD, 8'h00),
      known_row(1'b1, 1'b1, 8'hff),
      reg_row(REG_UNUSED_FIRST, 8'hff),
      reg_row(REG_UNUSED_LAST, 8'h5a),
      reg_row(led_blk_pkg::REG_ALGO_INDEX, 8'(PWM_UNUSED)),
      known_row(1'b0, 1'b0, 8'hff),
      reg_row(led_blk_pkg::REG_ALGO_INDEX, 8'(led_blk_pkg::PWM_OFF)),
      known_row(1'b0, 1'b0, led_blk_pkg::LEVEL_OFF),
      reg_row(led_blk_pkg::REG_MODE_SELECT, 8'(led_blk_pkg::MODE_SWITCH)),
      reg_row(led_blk_pkg::REG_PERIOD, 8'd3),
      reg_row(led_blk_pkg::REG_FLASH_WORD, 8'h05),
      reg_row(led_blk_pkg::REG_ALGO_INDEX, 8'(led_blk_pkg::SW_FLASH)),
      step_row(1'b1, 1'b0), step_row(1'b1, 1'b0), step_row(1'b1, 1'b0),
      step_row(1'b1, 1'b0), step_row(1'b1, 1'b0), step_row(1'b1, 1'b0),
      step_row(1'b1, 1'b0), step_row(1'b1, 1'b0),
      reg_row(led_blk_pkg::REG_ALGO_INDEX, 8'(led_blk_pkg::SW_PULSE)),
      known_row(1'b0, 1'b1, led_blk_pkg::LEVEL_FULL),
      step_row(1'b1, 1'b0), step_row(1'b1, 1'b0), step_row(1'b1, 1'b0),
      reg_row(led_blk_pkg::REG_ALGO_INDEX, 8'(SW_UNUSED)),
      step_row(1'b1, 1'b0),
      reg_row(led_blk_pkg::REG_PERIOD, 8'hff),
      step_row(1'b1, 1'b0),
      reg_row(led_blk_pkg::REG_PERIOD, 8'h00),
      step_row(1'b1, 1'b0)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_write) begin
        finish_items();
        write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_data);
      end else begin
        send_item(directed_rows[k].tick, directed_rows[k].restart,
                  directed_rows[k].typed, directed_rows[k].level);
      end
    end

    // Random phases: a fresh register setting, then a run of steps.
    for (phase = 0; steps_sent < TARGET_STEPS; phase++) begin
      finish_items();
      if (phase == 0 || $urandom_range(0, 99) < 60) begin
        write_reg(led_blk_pkg::REG_MODE_SELECT, 8'($urandom_range(0, 255)));
      end
      if (phase == 0 || $urandom_range(0, 99) < 60) begin
        // Mostly a defined algorithm, with junk in the unused upper bits.
        v = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 75) begin
          v[2:0] = 3'($urandom_range(0, 3));
        end
        write_reg(led_blk_pkg::REG_ALGO_INDEX, v);
      end
      if (phase == 0 || $urandom_range(0, 99) < 60) begin
        case ($urandom_range(0, 9))
          0: v = 8'h00;
          1: v = 8'hff;
          2: v = 8'($urandom_range(0, 255));
          default: v = 8'($urandom_range(1, 6));
        endcase
        write_reg(led_blk_pkg::REG_PERIOD, v);
      end
      if (phase == 0 || $urandom_range(0, 99) < 60) begin
        // Short flash phases most of the time so bursts complete often.
        v = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 70) begin
          v[7:2] = 6'($urandom_range(0, 3));
        end
        write_reg(led_blk_pkg::REG_FLASH_WORD, v);
      end
      if ($urandom_range(0, 99) < 10) begin
        write_reg(8'($urandom_range(int'(REG_UNUSED_FIRST), int'(REG_UNUSED_LAST))),
                  8'($urandom_range(0, 255)));
      end

      n_items     = $urandom_range(15, 60);
      tick_pct    = $urandom_range(40, 100);
      tx_idle_pct = IDLE_PCT;
      rx_idle_pct = IDLE_PCT;
      if (phase == LONG_RUN_PHASE) begin
        // Zero period with back-to-back ticks and no idling anywhere: long
        // enough to see the counter wrap through all 256 values.
        write_reg(led_blk_pkg::REG_PERIOD, 8'h00);
        n_items     = 520;
        tick_pct    = 100;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (phase == STALL_PHASE) begin
        // Receiver holds off while steps keep coming, so the input stalls.
        rx_hold_request = 1;
        tx_idle_pct     = 0;
        n_items         = 60;
      end
      for (int i = 0; i < n_items; i++) begin
        send_item($urandom_range(0, 99) < tick_pct, $urandom_range(0, 99) < RESTART_PCT,
                  1'b0, led_blk_pkg::LEVEL_OFF);
      end
    end

    finish_items();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_levels.size() != 0) begin
      $error("level: %0d results never arrived", expected_levels.size());
      mismatch_count++;
    end
    $display("Checked %0d channel steps across %0d random phases and %0d register writes.",
             steps_checked, phase, writes_done);
    $display("Both modes, out-of-range algorithms, zero period wrap and a held receiver ran.");
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
